// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL; all sample on clk_i and hold off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Consequent must hold in the cycle the antecedent holds
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/segint_pkg.sv =====
// ----------------------------------------------------------------------------
// segint_pkg
// Shared types and constants of the segment intersection block.
// ----------------------------------------------------------------------------
package segint_pkg;

  localparam int unsigned COORD_W        = 16;
  localparam int unsigned OUT_W          = 32;
  localparam int unsigned COORD_BITS_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF  = 16;
  localparam int unsigned QUEUE_DEPTH    = 2;

  // one request: two segments, four endpoints
  typedef struct packed {
    logic signed [COORD_W-1:0] first_ax;
    logic signed [COORD_W-1:0] first_ay;
    logic signed [COORD_W-1:0] first_bx;
    logic signed [COORD_W-1:0] first_by;
    logic signed [COORD_W-1:0] second_ax;
    logic signed [COORD_W-1:0] second_ay;
    logic signed [COORD_W-1:0] second_bx;
    logic signed [COORD_W-1:0] second_by;
  } seg_req_t;

  // one result
  typedef struct packed {
    logic                    found;
    logic signed [OUT_W-1:0] cross_x;
    logic signed [OUT_W-1:0] cross_y;
  } seg_res_t;

endpackage

// ===== hw/rtl/segint_front.sv =====
// ----------------------------------------------------------------------------
// segint_front
// Takes requests, forms orientation products and classifies the crossing.
// ----------------------------------------------------------------------------
module segint_front #(
  parameter int unsigned COORD_BITS = segint_pkg::COORD_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic                                 start_i,
  input  segint_pkg::seg_req_t                 req_i,
  output logic                                 push_o,
  output logic                                 found_o,
  output logic signed [2*COORD_BITS+2:0]       den_o,
  output logic signed [2*COORD_BITS+2:0]       det1_o,
  output logic signed [2*COORD_BITS+2:0]       det2_o,
  output logic signed [COORD_BITS:0]           bax_o,
  output logic signed [COORD_BITS:0]           bay_o,
  output logic signed [COORD_BITS:0]           dcx_o,
  output logic signed [COORD_BITS:0]           dcy_o
);
  import segint_pkg::*;

  localparam int unsigned C   = COORD_BITS;
  localparam int unsigned DFW = C + 1;
  localparam int unsigned PW  = 2*C + 2;
  localparam int unsigned CW  = 2*C + 3;

  function automatic logic signed [C-1:0] sx(input logic [COORD_W-1:0] raw);
    logic [31:0] e;
    e = 32'(raw);
    return $signed(e[C-1:0]);
  endfunction

  // stage 1: sign extended coordinates and edge differences
  logic              v1_q;
  logic signed [C-1:0]   ax_q, ay_q, bx_q, by_q, cx_q, cy_q, dx_q, dy_q;
  logic signed [DFW-1:0] bax_q, bay_q, cax_q, cay_q, dax_q, day_q;
  logic signed [DFW-1:0] cbx_q, cby_q, dbx_q, dby_q, dcx_q, dcy_q;
  logic signed [C-1:0]   ax, ay, bx, by, cx, cy, dx, dy;

  assign ax = sx(req_i.first_ax);
  assign ay = sx(req_i.first_ay);
  assign bx = sx(req_i.first_bx);
  assign by = sx(req_i.first_by);
  assign cx = sx(req_i.second_ax);
  assign cy = sx(req_i.second_ay);
  assign dx = sx(req_i.second_bx);
  assign dy = sx(req_i.second_by);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ax_q  <= ax;  ay_q <= ay;  bx_q <= bx;  by_q <= by;
      cx_q  <= cx;  cy_q <= cy;  dx_q <= dx;  dy_q <= dy;
      bax_q <= DFW'(bx) - DFW'(ax);
      bay_q <= DFW'(by) - DFW'(ay);
      cax_q <= DFW'(cx) - DFW'(ax);
      cay_q <= DFW'(cy) - DFW'(ay);
      dax_q <= DFW'(dx) - DFW'(ax);
      day_q <= DFW'(dy) - DFW'(ay);
      cbx_q <= DFW'(cx) - DFW'(bx);
      cby_q <= DFW'(cy) - DFW'(by);
      dbx_q <= DFW'(dx) - DFW'(bx);
      dby_q <= DFW'(dy) - DFW'(by);
      dcx_q <= DFW'(dx) - DFW'(cx);
      dcy_q <= DFW'(dy) - DFW'(cy);
    end
  end

  // stage 2: products of edge differences and of endpoint coordinates
  logic                 v2_q;
  logic signed [PW-1:0] p1a_q, p1b_q, p2a_q, p2b_q, p3a_q, p3b_q, p4a_q, p4b_q;
  logic signed [PW-1:0] pna_q, pnb_q, pe1a_q, pe1b_q, pe2a_q, pe2b_q;
  logic signed [DFW-1:0] bax2_q, bay2_q, dcx2_q, dcy2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1a_q  <= PW'(bax_q) * PW'(cay_q);
      p1b_q  <= PW'(bay_q) * PW'(cax_q);
      p2a_q  <= PW'(bax_q) * PW'(day_q);
      p2b_q  <= PW'(bay_q) * PW'(dax_q);
      p3a_q  <= PW'(cax_q) * PW'(day_q);
      p3b_q  <= PW'(cay_q) * PW'(dax_q);
      p4a_q  <= PW'(cbx_q) * PW'(dby_q);
      p4b_q  <= PW'(cby_q) * PW'(dbx_q);
      pna_q  <= PW'(bax_q) * PW'(dcy_q);
      pnb_q  <= PW'(bay_q) * PW'(dcx_q);
      pe1a_q <= PW'(ax_q) * PW'(by_q);
      pe1b_q <= PW'(ay_q) * PW'(bx_q);
      pe2a_q <= PW'(cx_q) * PW'(dy_q);
      pe2b_q <= PW'(cy_q) * PW'(dx_q);
      bax2_q <= bax_q;
      bay2_q <= bay_q;
      dcx2_q <= dcx_q;
      dcy2_q <= dcy_q;
    end
  end

  // stage 3: cross products, signs and classification
  logic signed [CW-1:0] s1, s2, s3, s4, den;
  logic                 cross_ok;

  assign s1  = CW'(p1a_q) - CW'(p1b_q);
  assign s2  = CW'(p2a_q) - CW'(p2b_q);
  assign s3  = CW'(p3a_q) - CW'(p3b_q);
  assign s4  = CW'(p4a_q) - CW'(p4b_q);
  assign den = CW'(pna_q) - CW'(pnb_q);

  // nonzero signs, each pair straddling, and a usable denominator
  assign cross_ok = (s1 != '0) && (s2 != '0) && (s3 != '0) && (s4 != '0) &&
                    (s1[CW-1] != s2[CW-1]) && (s3[CW-1] != s4[CW-1]) && (den != '0);

  logic v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en_i) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      found_o <= cross_ok;
      den_o   <= den;
      det1_o  <= CW'(pe1a_q) - CW'(pe1b_q);
      det2_o  <= CW'(pe2a_q) - CW'(pe2b_q);
      bax_o   <= bax2_q;
      bay_o   <= bay2_q;
      dcx_o   <= dcx2_q;
      dcy_o   <= dcy2_q;
    end
  end

  assign push_o = v3_q && en_i;

endmodule

// ===== hw/rtl/segint_fifo.sv =====
// ----------------------------------------------------------------------------
// segint_fifo
// Short queue between the classifying front and the arithmetic back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module segint_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = segint_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o,
  output logic             full_o
);
  import segint_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_q, rd_q;
  logic [NW-1:0]    cnt_q;
  logic             do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == NW'(DEPTH));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  `ASSERT_ALWAYS(a_no_overflow, !(push_i && full_o), "push into full queue")
  `ASSERT_ALWAYS(a_cnt_range, cnt_q <= NW'(DEPTH), "queue count out of range")

endmodule

// ===== hw/rtl/segint_back.sv =====
// ----------------------------------------------------------------------------
// segint_back
// Numerator products, magnitudes and a pipelined restoring divider per axis.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module segint_back #(
  parameter int unsigned COORD_BITS = segint_pkg::COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = segint_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           pop_i,
  input  logic                           found_i,
  input  logic signed [2*COORD_BITS+2:0] den_i,
  input  logic signed [2*COORD_BITS+2:0] det1_i,
  input  logic signed [2*COORD_BITS+2:0] det2_i,
  input  logic signed [COORD_BITS:0]     bax_i,
  input  logic signed [COORD_BITS:0]     bay_i,
  input  logic signed [COORD_BITS:0]     dcx_i,
  input  logic signed [COORD_BITS:0]     dcy_i,
  output logic                           res_valid_o,
  output segint_pkg::seg_res_t           res_o
);
  import segint_pkg::*;

  localparam int unsigned C   = COORD_BITS;
  localparam int unsigned CW  = 2*C + 3;
  localparam int unsigned NW  = 3*C + 5;
  localparam int unsigned DW  = CW;
  localparam int unsigned DVW = NW + FRAC_BITS;
  localparam int unsigned QB  = C + FRAC_BITS;
  localparam int unsigned QX  = (QB > 33) ? QB : 33;
  localparam logic [QX-1:0] LIM_NEG = QX'(64'h8000_0000);
  localparam logic [QX-1:0] LIM_POS = QX'(64'h7FFF_FFFF);

  // B1: numerator products
  logic                 b1_v_q, b1_f_q;
  logic signed [CW-1:0] b1_den_q;
  logic signed [NW-1:0] m1_q, m2_q, m3_q, m4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_v_q <= 1'b0;
    end else begin
      b1_v_q <= pop_i;
    end
  end

  always_ff @(posedge clk_i) begin
    b1_f_q   <= found_i;
    b1_den_q <= den_i;
    m1_q     <= NW'(det1_i) * NW'(dcx_i);
    m2_q     <= NW'(det2_i) * NW'(bax_i);
    m3_q     <= NW'(det1_i) * NW'(dcy_i);
    m4_q     <= NW'(det2_i) * NW'(bay_i);
  end

  // B2: numerators
  logic                 b2_v_q, b2_f_q;
  logic signed [CW-1:0] b2_den_q;
  logic signed [NW-1:0] nx_q, ny_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b2_v_q <= 1'b0;
    end else begin
      b2_v_q <= b1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b2_f_q   <= b1_f_q;
    b2_den_q <= b1_den_q;
    nx_q     <= m2_q - m1_q;
    ny_q     <= m4_q - m3_q;
  end

  // B3: magnitudes and result signs
  logic            b3_v_q, b3_f_q;
  logic [1:0]      b3_neg_q;
  logic [DW-1:0]   b3_d_q;
  logic [NW-1:0]   magx_q, magy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b3_v_q <= 1'b0;
    end else begin
      b3_v_q <= b2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b3_f_q      <= b2_f_q;
    b3_neg_q[0] <= nx_q[NW-1] ^ b2_den_q[CW-1];
    b3_neg_q[1] <= ny_q[NW-1] ^ b2_den_q[CW-1];
    b3_d_q      <= b2_den_q[CW-1] ? DW'(-b2_den_q) : DW'(b2_den_q);
    magx_q      <= nx_q[NW-1] ? NW'(-nx_q) : NW'(nx_q);
    magy_q      <= ny_q[NW-1] ? NW'(-ny_q) : NW'(ny_q);
  end

  // divider pipeline, one quotient bit per stage; index 0 is the feed
  logic            dv_v   [QB+1];
  logic            dv_f   [QB+1];
  logic [1:0]      dv_neg [QB+1];
  logic [DW-1:0]   dv_d   [QB+1];
  logic [DW-1:0]   dv_rem [2][QB+1];
  logic [QB-1:0]   dv_lo  [2][QB+1];
  logic [QB-1:0]   dv_quo [2][QB+1];
  logic [DVW-1:0]  dvd    [2];

  assign dvd[0]    = DVW'(magx_q) << FRAC_BITS;
  assign dvd[1]    = DVW'(magy_q) << FRAC_BITS;
  assign dv_v[0]   = b3_v_q;
  assign dv_f[0]   = b3_f_q;
  assign dv_neg[0] = b3_neg_q;
  assign dv_d[0]   = b3_d_q;

  // the geometry bounds the quotient to QB bits, so the top part is below the divisor
  for (genvar l = 0; l < 2; l++) begin : g_feed
    assign dv_rem[l][0] = DW'(dvd[l] >> QB);
    assign dv_lo[l][0]  = QB'(dvd[l]);
    assign dv_quo[l][0] = '0;
  end

  for (genvar k = 0; k < QB; k++) begin : g_stage
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v[k+1] <= 1'b0;
      end else begin
        dv_v[k+1] <= dv_v[k];
      end
    end

    always_ff @(posedge clk_i) begin
      dv_f[k+1]   <= dv_f[k];
      dv_neg[k+1] <= dv_neg[k];
      dv_d[k+1]   <= dv_d[k];
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [DW:0] rem2, diff;
      logic        ge;

      assign rem2 = {dv_rem[l][k], dv_lo[l][k][QB-1]};
      assign diff = rem2 - {1'b0, dv_d[k]};
      assign ge   = (rem2 >= {1'b0, dv_d[k]});

      always_ff @(posedge clk_i) begin
        dv_rem[l][k+1] <= ge ? diff[DW-1:0] : rem2[DW-1:0];
        dv_lo[l][k+1]  <= dv_lo[l][k] << 1;
        dv_quo[l][k+1] <= {dv_quo[l][k][QB-2:0], ge};
      end
    end
  end

  // sign, saturation and zeroing of non-crossings
  function automatic logic [OUT_W-1:0] fix_out(input logic [QB-1:0] q, input logic neg);
    logic [QX-1:0] qx;
    logic [QX-1:0] qn;
    qx = QX'(q);
    qn = -qx;
    if (neg) begin
      return (qx > LIM_NEG) ? 32'h8000_0000 : qn[OUT_W-1:0];
    end
    return (qx > LIM_POS) ? 32'h7FFF_FFFF : qx[OUT_W-1:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_o <= 1'b0;
    end else begin
      res_valid_o <= dv_v[QB];
    end
  end

  always_ff @(posedge clk_i) begin
    res_o.found   <= dv_f[QB];
    res_o.cross_x <= dv_f[QB] ? fix_out(dv_quo[0][QB], dv_neg[QB][0]) : '0;
    res_o.cross_y <= dv_f[QB] ? fix_out(dv_quo[1][QB], dv_neg[QB][1]) : '0;
  end

  `ASSERT_IMPL(a_div_x_range, dv_v[0] && dv_f[0], dv_rem[0][0] < dv_d[0],
               "x quotient exceeds divider width")
  `ASSERT_IMPL(a_div_y_range, dv_v[0] && dv_f[0], dv_rem[1][0] < dv_d[0],
               "y quotient exceeds divider width")
  `ASSERT_IMPL(a_miss_zero, res_valid_o && !res_o.found,
               (res_o.cross_x == '0) && (res_o.cross_y == '0), "non-crossing not zeroed")

endmodule

// ===== hw/rtl/segment_intersection_top.sv =====
// ----------------------------------------------------------------------------
// segment_intersection_top
// Proper crossing test of two 2D segments with the crossing point in fixed point.
// ----------------------------------------------------------------------------
// Path from start to result strobe: three front stages, the queue, three back stages,
//   the one-bit-per-stage divider and the output register.
// Throughput: one request per cycle while busy is low; busy only rises if the queue ever fills.
// Reset: asynchronous, clears all valid flags and queue pointers; no clearing pass.
// Results are strobed for one cycle and cannot be held off by the receiver.
module segment_intersection_top #(
  parameter int unsigned COORD_BITS = segint_pkg::COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = segint_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  segint_pkg::seg_req_t req_i,
  output logic                 res_valid_o,
  output segint_pkg::seg_res_t res_o
);
  import segint_pkg::*;

  localparam int unsigned CW  = 2*COORD_BITS + 3;
  localparam int unsigned DFW = COORD_BITS + 1;
  localparam int unsigned EW  = 1 + 3*CW + 4*DFW;

  logic                  push, pop, q_empty, q_full;
  logic                  f_found;
  logic signed [CW-1:0]  f_den, f_det1, f_det2;
  logic signed [DFW-1:0] f_bax, f_bay, f_dcx, f_dcy;
  logic [EW-1:0]         q_in, q_out;

  logic                  b_found;
  logic signed [CW-1:0]  b_den, b_det1, b_det2;
  logic signed [DFW-1:0] b_bax, b_bay, b_dcx, b_dcy;

  assign busy = q_full;

  // front: accept and classify
  segint_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (!q_full),
    .start_i (start && !busy),
    .req_i   (req_i),
    .push_o  (push),
    .found_o (f_found),
    .den_o   (f_den),
    .det1_o  (f_det1),
    .det2_o  (f_det2),
    .bax_o   (f_bax),
    .bay_o   (f_bay),
    .dcx_o   (f_dcx),
    .dcy_o   (f_dcy)
  );

  assign q_in = {f_found, f_den, f_det1, f_det2, f_bax, f_bay, f_dcx, f_dcy};

  // queue between front and back
  segint_fifo #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (q_in),
    .pop_i   (pop),
    .data_o  (q_out),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  // the back never stalls, so it drains one entry every cycle while the queue is not empty
  assign pop = !q_empty;
  assign {b_found, b_den, b_det1, b_det2, b_bax, b_bay, b_dcx, b_dcy} = q_out;

  segint_back #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_i       (pop),
    .found_i     (b_found),
    .den_i       (b_den),
    .det1_i      (b_det1),
    .det2_i      (b_det2),
    .bax_i       (b_bax),
    .bay_i       (b_bay),
    .dcx_i       (b_dcx),
    .dcy_i       (b_dcy),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule
